### src/jacm_pkg.sv
// Shared constants and register codes for the joystick axis calibrated map.
package jacm_pkg;

  localparam int SAMPLE_BITS_DEFAULT = 12;
  localparam int OUT_BITS = 8;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 12;

  // Register indexes on the configuration channel.
  localparam logic [CFG_INDEX_BITS-1:0] REG_MODE        = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EDGE_LOW    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_LOW  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_HIGH = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EDGE_HIGH   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OUT_MIN     = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OUT_MAX     = 3'd6;

  // Operating modes.
  localparam logic [1:0] MODE_TRACK  = 2'd0;
  localparam logic [1:0] MODE_CENTER = 2'd1;
  localparam logic [1:0] MODE_EDGE   = 2'd2;

  // Register reset values.
  localparam logic [CFG_DATA_BITS-1:0] EDGE_LOW_RESET    = 12'd0;
  localparam logic [CFG_DATA_BITS-1:0] CENTER_LOW_RESET  = 12'd2000;
  localparam logic [CFG_DATA_BITS-1:0] CENTER_HIGH_RESET = 12'd2095;
  localparam logic [CFG_DATA_BITS-1:0] EDGE_HIGH_RESET   = 12'd4095;
  localparam logic [OUT_BITS-1:0]      OUT_MIN_RESET     = 8'd48;
  localparam logic [OUT_BITS-1:0]      OUT_MAX_RESET     = 8'd111;

  // Smallest half width of the centre window, and the proposal margin.
  localparam int MIN_HALF = 32;
  localparam int MARGIN = 4;

endpackage

### src/jacm_if.sv
// Handshake interfaces for samples, results and configuration writes.
interface jacm_in_if #(
  parameter int SAMPLE_BITS = jacm_pkg::SAMPLE_BITS_DEFAULT
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink (input valid, input sample, input restart, output ready);
endinterface

interface jacm_out_if #(
  parameter int SAMPLE_BITS = jacm_pkg::SAMPLE_BITS_DEFAULT
);
  logic                          valid;
  logic                          ready;
  logic [jacm_pkg::OUT_BITS-1:0] position;
  logic                          moved;
  logic [SAMPLE_BITS-1:0]        seen_min;
  logic [SAMPLE_BITS-1:0]        seen_max;
  logic                          proposal_valid;
  logic [SAMPLE_BITS-1:0]        proposed_low;
  logic [SAMPLE_BITS-1:0]        proposed_high;

  modport source (output valid, output position, output moved, output seen_min,
                  output seen_max, output proposal_valid, output proposed_low,
                  output proposed_high, input ready);
  modport sink (input valid, input position, input moved, input seen_min,
                input seen_max, input proposal_valid, input proposed_low,
                input proposed_high, output ready);
endinterface

interface jacm_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [jacm_pkg::CFG_INDEX_BITS-1:0] index;
  logic [jacm_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### src/jacm_div.sv
// Restoring serial divider giving an OUT_BITS quotient, one bit per cycle.
module jacm_div #(
  parameter int DEN_BITS = jacm_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [DEN_BITS+jacm_pkg::OUT_BITS-1:0] num,
  input  logic [DEN_BITS-1:0]                    den,
  output logic                                   done,
  output logic [jacm_pkg::OUT_BITS-1:0]          quo
);

  localparam int QB = jacm_pkg::OUT_BITS;
  localparam int CNT_BITS = (QB > 1) ? $clog2(QB) : 1;

  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  logic [DEN_BITS-1:0] rem;
  logic [DEN_BITS-1:0] den_q;
  logic [QB-1:0]       low;
  logic [DEN_BITS:0]   trial;
  logic                fits;
  logic [DEN_BITS:0]   diff;

  // The caller guarantees the quotient fits, so the upper numerator bits
  // already sit below the divisor and only the low bits need stepping.
  assign trial = {rem, low[QB-1]};
  assign fits  = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};
  assign quo   = low;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        done  <= 1'b0;
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= num[DEN_BITS+QB-1:QB];
        low   <= num[QB-1:0];
        den_q <= den;
      end else if (busy) begin
        rem  <= fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
        low  <= {low[QB-2:0], fits};
        cnt  <= cnt + 1'b1;
        done <= (cnt == CNT_BITS'(QB - 1));
        if (cnt == CNT_BITS'(QB - 1)) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start");
  a_rem_below: assert property (@(posedge clk) disable iff (rst) busy |-> rem < den_q)
    else $error("divider remainder not below divisor");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");

endmodule

### src/joystick_axis_calibrated_map.sv
// Top level of the joystick axis calibrated map: sequencer, tracking and output register.
//
// One instance serves one joystick axis. Each request on the samples channel carries a
// raw ADC sample and a restart flag; restart begins new min/max tracking with that sample.
// Each sample gives exactly one request on the results channel: the mapped position, a
// moved flag, the smallest and largest samples since restart and, in the calibration
// modes, proposed new calibration limits.
// Configuration writes go through the cfg channel, which is always ready; the register
// index follows the order mode, edge_low, center_low, center_high, edge_high, out_min,
// out_max, and other indexes are ignored. Write only while no sample is in flight.
// Sequencing: the block takes one sample at a time. A sample that lands in the dead zone or
// beyond a segment end is done without the divider; one that needs the linear
// interpolation waits on the serial divider, which yields one quotient bit per cycle over
// the 8 bits of the position.
// The result sits in an output register, so a stalled receiver does not stop the next
// sample being accepted; only its final write waits until the earlier result is taken.
// Reset (synchronous, active high) restores the register defaults, clears the tracking
// state and empties the output register.
module joystick_axis_calibrated_map #(
  parameter int SAMPLE_BITS = jacm_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  jacm_in_if.sink    samples,
  jacm_out_if.source results,
  jacm_cfg_if.sink   cfg
);

  localparam int SB = SAMPLE_BITS;
  localparam int OB = jacm_pkg::OUT_BITS;
  localparam int CB = jacm_pkg::CFG_DATA_BITS;
  localparam logic [SB-1:0] SAMPLE_MAX = {SB{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_CTR,
    S_WIN,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  // Configuration registers, stored as written.
  logic [1:0]    mode;
  logic [CB-1:0] edge_low;
  logic [CB-1:0] center_low;
  logic [CB-1:0] center_high;
  logic [CB-1:0] edge_high;
  logic [OB-1:0] out_min;
  logic [OB-1:0] out_max;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= jacm_pkg::MODE_TRACK;
      edge_low    <= jacm_pkg::EDGE_LOW_RESET;
      center_low  <= jacm_pkg::CENTER_LOW_RESET;
      center_high <= jacm_pkg::CENTER_HIGH_RESET;
      edge_high   <= jacm_pkg::EDGE_HIGH_RESET;
      out_min     <= jacm_pkg::OUT_MIN_RESET;
      out_max     <= jacm_pkg::OUT_MAX_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        jacm_pkg::REG_MODE:        mode        <= cfg.data[1:0];
        jacm_pkg::REG_EDGE_LOW:    edge_low    <= cfg.data;
        jacm_pkg::REG_CENTER_LOW:  center_low  <= cfg.data;
        jacm_pkg::REG_CENTER_HIGH: center_high <= cfg.data;
        jacm_pkg::REG_EDGE_HIGH:   edge_high   <= cfg.data;
        jacm_pkg::REG_OUT_MIN:     out_min     <= cfg.data[OB-1:0];
        jacm_pkg::REG_OUT_MAX:     out_max     <= cfg.data[OB-1:0];
        default: ;
      endcase
    end
  end

  // The calibration registers are brought to the sample width: truncated when the
  // sample is narrower, zero-extended when it is wider.
  logic [SB+CB-1:0] el_ext, cl_ext, ch_ext, eh_ext;
  logic [SB-1:0]    el, cl, ch, eh;
  logic [OB-1:0]    olo, ohi;
  logic             center_mode;

  assign el_ext = {{SB{1'b0}}, edge_low};
  assign cl_ext = {{SB{1'b0}}, center_low};
  assign ch_ext = {{SB{1'b0}}, center_high};
  assign eh_ext = {{SB{1'b0}}, edge_high};
  assign el = el_ext[SB-1:0];
  assign cl = cl_ext[SB-1:0];
  assign ch = ch_ext[SB-1:0];
  assign eh = eh_ext[SB-1:0];

  // A reversed output range collapses onto out_min; mode 3 behaves as track mode.
  assign olo = out_min;
  assign ohi = (out_max < out_min) ? out_min : out_max;
  assign center_mode = (mode == jacm_pkg::MODE_CENTER);

  state_t        state;
  logic [SB-1:0] s_q;
  logic          has_sample;
  logic [SB-1:0] track_min;
  logic [SB-1:0] track_max;
  logic [OB-1:0] last_position;
  logic          shown;

  logic [SB-1:0] center;
  logic [SB-1:0] half;
  logic [OB-1:0] mid;
  logic [SB-1:0] seg_lo;
  logic [SB-1:0] seg_hi;
  logic [OB-1:0] seg_olo;
  logic [OB-1:0] seg_ohi;
  logic          dead;
  logic [OB-1:0] pos;

  // Centre-window arithmetic.
  logic [SB:0]   ctr_sum;
  logic [SB-1:0] dz_width;
  logic [SB:0]   win_top;
  logic [OB-1:0] out_span;

  assign ctr_sum  = {1'b0, cl} + {1'b0, ch};
  assign dz_width = ch - cl;
  assign win_top  = {1'b0, center} + {1'b0, half};
  assign out_span = ohi - olo;

  // Interpolation for a sample strictly inside its segment.
  logic [SB-1:0]    seg_off;
  logic [SB-1:0]    seg_len;
  logic [OB-1:0]    seg_span;
  logic [SB+OB-1:0] product;
  logic             div_start;
  logic             div_done;
  logic [OB-1:0]    div_quo;

  assign seg_off   = s_q - seg_lo;
  assign seg_len   = seg_hi - seg_lo;
  assign seg_span  = seg_ohi - seg_olo;
  assign product   = seg_off * seg_span;
  assign div_start = (state == S_MUL) && !dead && (s_q > seg_lo) && (s_q < seg_hi);

  jacm_div #(
    .DEN_BITS(SB)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (product),
    .den   (seg_len),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Proposals from the extremes seen so far, with the margin in centre mode.
  logic [SB-1:0] prop_lo;
  logic [SB-1:0] prop_hi;
  logic          prop_valid;

  always_comb begin
    prop_valid = 1'b0;
    prop_lo    = '0;
    prop_hi    = '0;
    case (mode)
      jacm_pkg::MODE_CENTER: begin
        prop_valid = 1'b1;
        prop_lo = (track_min > SB'(jacm_pkg::MARGIN)) ?
                  track_min - SB'(jacm_pkg::MARGIN) : '0;
        prop_hi = (track_max < SAMPLE_MAX - SB'(jacm_pkg::MARGIN)) ?
                  track_max + SB'(jacm_pkg::MARGIN) : SAMPLE_MAX;
      end
      jacm_pkg::MODE_EDGE: begin
        prop_valid = 1'b1;
        prop_lo = track_min;
        prop_hi = track_max;
      end
      default: ;
    endcase
  end

  logic in_take;
  logic out_free;

  assign samples.ready = (state == S_IDLE);
  assign in_take  = samples.valid && samples.ready;
  assign out_free = !results.valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      has_sample    <= 1'b0;
      track_min     <= '0;
      track_max     <= '0;
      last_position <= '0;
      shown         <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      // A new result loaded in the same cycle takes the place of the one just taken.
      if (results.valid && results.ready && !(state == S_DONE && out_free)) begin
        results.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            s_q <= samples.sample;
            if (samples.restart || !has_sample) begin
              has_sample <= 1'b1;
              track_min  <= samples.sample;
              track_max  <= samples.sample;
            end else begin
              if (samples.sample < track_min) track_min <= samples.sample;
              if (samples.sample > track_max) track_max <= samples.sample;
            end
            if (samples.restart) begin
              shown         <= 1'b0;
              last_position <= '0;
            end
            state <= S_CTR;
          end
        end
        S_CTR: begin
          // Window half width: the dead-zone width, but never below the minimum.
          center <= ctr_sum[SB:1];
          half   <= (ch >= cl && dz_width >= SB'(jacm_pkg::MIN_HALF)) ?
                    dz_width : SB'(jacm_pkg::MIN_HALF);
          mid    <= olo + (out_span >> 1);
          state  <= S_WIN;
        end
        S_WIN: begin
          if (center_mode) begin
            dead    <= 1'b0;
            seg_lo  <= (center > half) ? center - half : '0;
            seg_hi  <= (win_top <= {1'b0, SAMPLE_MAX}) ? win_top[SB-1:0] : SAMPLE_MAX;
            seg_olo <= olo;
            seg_ohi <= ohi;
          end else if (s_q <= cl) begin
            dead    <= 1'b0;
            seg_lo  <= el;
            seg_hi  <= cl;
            seg_olo <= olo;
            seg_ohi <= mid;
          end else if (s_q >= ch) begin
            dead    <= 1'b0;
            seg_lo  <= ch;
            seg_hi  <= eh;
            seg_olo <= mid;
            seg_ohi <= ohi;
          end else begin
            dead <= 1'b1;
          end
          state <= S_MUL;
        end
        S_MUL: begin
          // The low end is tested first: in an empty or reversed segment a sample at or below
          // its low end gives the low output, and any other sample gives the high output.
          if (dead) begin
            pos   <= mid;
            state <= S_DONE;
          end else if (s_q <= seg_lo) begin
            pos   <= seg_olo;
            state <= S_DONE;
          end else if (s_q >= seg_hi) begin
            pos   <= seg_ohi;
            state <= S_DONE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            pos   <= seg_olo + div_quo;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            results.valid          <= 1'b1;
            results.position       <= pos;
            results.moved          <= !(shown && last_position == pos);
            results.seen_min       <= track_min;
            results.seen_max       <= track_max;
            results.proposal_valid <= prop_valid;
            results.proposed_low   <= prop_lo;
            results.proposed_high  <= prop_hi;
            last_position          <= pos;
            shown                  <= 1'b1;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_take |=> !samples.ready)
    else $error("sample accepted while a previous one was in flight");
  a_track_order: assert property (@(posedge clk) disable iff (rst)
    has_sample |-> track_min <= track_max)
    else $error("tracked minimum above tracked maximum");
  a_div_in_step: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide step");

endmodule
